// ===== rtl/core/segsp_pkg.sv =====
// Shared constants, types and microcode fields of the ancestry segment splitter.
package segsp_pkg;

   localparam int MAX_BREAKS  = 16;
   localparam int POS_BITS    = 20;
   localparam int PARENT_BITS = 16;
   localparam int CHROM_BITS  = 6;
   localparam int FUNC_BITS   = 2;

   // Counters hold 0..MAX_BREAKS; the store index covers 0..MAX_BREAKS-1.
   localparam int CNT_BITS = $clog2(MAX_BREAKS + 1);
   localparam int IDX_BITS = (MAX_BREAKS > 1) ? $clog2(MAX_BREAKS) : 1;

   localparam int REQ_RAW_BITS  = PARENT_BITS + 1 + 3 * POS_BITS + CHROM_BITS;
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8;
   localparam int REQ_PAD_BITS  = REQ_DATA_BITS - REQ_RAW_BITS;

   localparam int RSP_RAW_BITS  = PARENT_BITS + CHROM_BITS + 1 + 2 * POS_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - RSP_RAW_BITS;

   localparam logic [FUNC_BITS-1:0] FUNC_START   = FUNC_BITS'(0);
   localparam logic [FUNC_BITS-1:0] FUNC_BREAK   = FUNC_BITS'(1);
   localparam logic [FUNC_BITS-1:0] FUNC_SEGMENT = FUNC_BITS'(2);

   typedef logic [POS_BITS-1:0] pos_type;

   typedef struct packed {
      logic [REQ_PAD_BITS-1:0] pad;
      logic [CHROM_BITS-1:0]   chrom_number;
      pos_type                 seg_end;
      pos_type                 seg_start;
      pos_type                 break_pos;
      logic                    start_chrom;
      logic [PARENT_BITS-1:0]  parent_id;
   } req_data_type;

   typedef struct packed {
      logic [RSP_PAD_BITS-1:0] pad;
      pos_type                 piece_end;
      pos_type                 piece_start;
      logic                    piece_copy;
      logic [CHROM_BITS-1:0]   piece_chrom_number;
      logic [PARENT_BITS-1:0]  piece_parent;
   } rsp_data_type;

   typedef struct packed {
      logic                   last;
      pos_type                piece_end;
      pos_type                piece_start;
      logic                   copy;
      logic [CHROM_BITS-1:0]  chrom;
      logic [PARENT_BITS-1:0] parent;
   } piece_type;

   typedef enum logic [2:0] {
      STEP_FETCH,
      STEP_START,
      STEP_BREAK,
      STEP_WALK,
      STEP_TAIL
   } step_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_START,
      ACT_BREAK,
      ACT_WALK,
      ACT_TAIL
   } act_type;

   typedef enum logic [1:0] {
      JMP_FUNC,
      JMP_GOTO,
      JMP_LOOP
   } jmp_type;

   typedef struct packed {
      logic     accept;
      act_type  act;
      jmp_type  jmp;
      step_type target;
   } ctl_type;

   typedef struct packed {
      act_type act;
      logic    fire;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic walk_emit;
      logic tail_emit;
   } sts_type;

endpackage

// ===== rtl/core/segsp_walk_dp.sv =====
// Datapath of the splitter: breakpoint file, walk cursor, copy parity and piece forming.
module segsp_walk_dp
   import segsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_load,
   input  req_data_type item_data,
   input  cmd_type      cmd,
   output sts_type      sts,
   output piece_type    piece
);

   req_data_type item_ff, item_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] cursor_ff, cursor_in;
   logic parity_ff, parity_in;
   logic [PARENT_BITS-1:0] parent_ff, parent_in;
   pos_type prev_ff, prev_in;
   pos_type bp_ff;
   pos_type break_store_ff [MAX_BREAKS];

   pos_type seg_a, seg_b, bp, from_pos;
   logic more, use_prev, bp_low, bp_inside, walk_done;
   logic advance, store_we;

   always_comb begin
      seg_a     = item_ff.seg_start;
      seg_b     = item_ff.seg_end;
      bp        = bp_ff;
      more      = cursor_ff < count_ff;
      // The previous breakpoint starts the piece when it lies inside the segment.
      use_prev  = (cursor_ff != '0) && (prev_ff > seg_a) && (prev_ff <= seg_b);
      from_pos  = use_prev ? prev_ff : seg_a;
      bp_low    = bp <= seg_a;
      bp_inside = !bp_low && (bp <= seg_b);
      walk_done = !more || (!bp_low && (bp > seg_b));

      sts.walk_done = walk_done;
      sts.walk_emit = more && bp_inside && (from_pos < bp);
      sts.tail_emit = seg_a <= seg_b;

      advance  = (cmd.act == ACT_WALK) && cmd.fire && !walk_done;
      store_we = (cmd.act == ACT_BREAK) && cmd.fire && (count_ff < CNT_BITS'(MAX_BREAKS));

      item_in   = item_load ? item_data : item_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      parity_in = parity_ff;
      parent_in = parent_ff;
      prev_in   = prev_ff;

      case (cmd.act)
         ACT_START: begin
            if (cmd.fire) begin
               parent_in = item_ff.parent_id;
               parity_in = item_ff.start_chrom;
               count_in  = '0;
               cursor_in = '0;
            end
         end
         ACT_BREAK: begin
            if (store_we) begin
               count_in = count_ff + CNT_BITS'(1);
            end
         end
         ACT_WALK: begin
            if (advance) begin
               cursor_in = cursor_ff + CNT_BITS'(1);
               parity_in = ~parity_ff;
               prev_in   = bp;
            end
         end
         default: begin
         end
      endcase

      piece.parent      = parent_ff;
      piece.chrom       = item_ff.chrom_number;
      piece.copy        = parity_ff;
      piece.piece_start = from_pos;
      piece.last        = (cmd.act == ACT_TAIL);
      piece.piece_end   = (cmd.act == ACT_TAIL) ? seg_b : (bp - POS_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         parity_ff <= 1'b0;
         parent_ff <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         parity_ff <= parity_in;
         parent_ff <= parent_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prev_ff <= prev_in;
   end

   // The read port follows the next cursor, so the breakpoint under the cursor is ready in
   // every walk cycle. A breakpoint written at the cursor is picked up in the fetch step.
   always_ff @(posedge clock) begin
      if (store_we) begin
         break_store_ff[count_ff[IDX_BITS-1:0]] <= item_ff.break_pos;
      end
      bp_ff <= break_store_ff[cursor_in[IDX_BITS-1:0]];
   end

endmodule

// ===== rtl/core/ancestry_segment_splitter.sv =====
// Top level of the ancestry segment splitter: microcode sequencer and result register.
//
//   channel | direction | tdata / tuser / tlast
//   --------+-----------+--------------------------------------------------------------
//   req_    | in        | tuser func; tdata parent, start copy, breakpoint, segment, chrom
//   rsp_    | out       | tdata one piece of a segment; tlast on the remainder piece
//
// A start item or a breakpoint item passes through the fetch step, then one execute step.
// A segment item passes through the fetch, walk and tail steps; the walk step examines one
// breakpoint per cycle through the single read port of the breakpoint file, except while
// a piece waits for the result register to free. Each piece is written to the result
// register at the end of its step and appears on rsp_ in the next cycle.
// Reset is synchronous and clears the sequencer, the counters, the copy parity, the held
// parent and the result valid; the breakpoint file is not cleared, since only loaded
// entries are ever read.
// A step that emits a piece waits while the result register holds an item not yet taken.
module ancestry_segment_splitter
   import segsp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tuser: func
   input  logic [FUNC_BITS-1:0]     req_tuser,
   // tdata from bit 0 up: parent_id, start_chrom, break_pos, seg_start, seg_end,
   // chrom_number, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata from bit 0 up: piece_parent, piece_chrom_number, piece_copy, piece_start,
   // piece_end, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // tlast: piece_last
   output logic                     rsp_tlast
);

   step_type  step_ff, step_in;
   ctl_type   ctl;
   cmd_type   cmd;
   sts_type   sts;
   piece_type piece;
   piece_type rsp_piece_ff, rsp_piece_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accepted, need_emit, out_free, go, load_out;
   rsp_data_type rsp_data;

   // Microcode table: one control word per step.
   always_comb begin
      case (step_ff)
         STEP_FETCH: ctl = '{accept: 1'b1, act: ACT_NONE,  jmp: JMP_FUNC, target: STEP_FETCH};
         STEP_START: ctl = '{accept: 1'b0, act: ACT_START, jmp: JMP_GOTO, target: STEP_FETCH};
         STEP_BREAK: ctl = '{accept: 1'b0, act: ACT_BREAK, jmp: JMP_GOTO, target: STEP_FETCH};
         STEP_WALK:  ctl = '{accept: 1'b0, act: ACT_WALK,  jmp: JMP_LOOP, target: STEP_TAIL};
         STEP_TAIL:  ctl = '{accept: 1'b0, act: ACT_TAIL,  jmp: JMP_GOTO, target: STEP_FETCH};
         default:    ctl = '{accept: 1'b0, act: ACT_NONE,  jmp: JMP_GOTO, target: STEP_FETCH};
      endcase
   end

   assign req_tready = ctl.accept;
   assign accepted   = req_tvalid && req_tready;

   // A step that emits can run only when the result register is free or draining.
   always_comb begin
      need_emit = ((ctl.act == ACT_WALK) && sts.walk_emit) ||
                  ((ctl.act == ACT_TAIL) && sts.tail_emit);
      out_free  = !rsp_valid_ff || rsp_tready;
      go        = !need_emit || out_free;
      load_out  = need_emit && out_free;
      cmd.act   = ctl.act;
      cmd.fire  = go;
   end

   // Step counter with conditional jumps.
   always_comb begin
      step_in = step_ff;
      case (ctl.jmp)
         JMP_FUNC: begin
            if (accepted) begin
               case (req_tuser)
                  FUNC_START:   step_in = STEP_START;
                  FUNC_BREAK:   step_in = STEP_BREAK;
                  FUNC_SEGMENT: step_in = STEP_WALK;
                  default:      step_in = STEP_FETCH;
               endcase
            end
         end
         JMP_GOTO: begin
            if (go) begin
               step_in = ctl.target;
            end
         end
         JMP_LOOP: begin
            if (go && sts.walk_done) begin
               step_in = ctl.target;
            end
         end
         default: begin
            step_in = STEP_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   segsp_walk_dp u_walk_dp (
      .clock     (clock),
      .reset     (reset),
      .item_load (accepted),
      .item_data (req_data_type'(req_tdata)),
      .cmd       (cmd),
      .sts       (sts),
      .piece     (piece)
   );

   // Result register: it parts the walk from the consumer of pieces.
   always_comb begin
      rsp_piece_in = load_out ? piece : rsp_piece_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_piece_ff <= rsp_piece_in;
   end

   always_comb begin
      rsp_data.pad                = '0;
      rsp_data.piece_end          = rsp_piece_ff.piece_end;
      rsp_data.piece_start        = rsp_piece_ff.piece_start;
      rsp_data.piece_copy         = rsp_piece_ff.copy;
      rsp_data.piece_chrom_number = rsp_piece_ff.chrom;
      rsp_data.piece_parent       = rsp_piece_ff.parent;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data;
   assign rsp_tlast  = rsp_piece_ff.last;

   // A segment item always enters the walk in the next cycle.
   a_segment_walks: assert property (@(posedge clock) disable iff (reset)
      (accepted && (req_tuser == FUNC_SEGMENT)) |=> (step_ff == STEP_WALK))
      else $error("segment item did not start the walk");

   // Every piece handed out is a nonempty range.
   a_piece_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_piece_ff.piece_start <= rsp_piece_ff.piece_end))
      else $error("piece start lies after its end");

   // A piece is never written over before it has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_piece_ff)))
      else $error("pending piece was lost");

   // A walk that is done moves on to the tail step in the next cycle.
   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == STEP_WALK) && sts.walk_done) |=> (step_ff == STEP_TAIL))
      else $error("walk did not end at the tail step");

endmodule

// ===== tb/ancestry_segment_splitter_test.sv =====
// Self-checking testbench for the ancestry segment splitter: stream stimulus and piece checks.
module ancestry_segment_splitter_test;
   import segsp_pkg::*;

   // The func code that the splitter has no use for; such items are dropped without a result.
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = FUNC_BITS'(3);

   localparam int unsigned POS_MAX      = (1 << POS_BITS) - 1;
   localparam int unsigned RANDOM_ITEMS = 345;
   // Cycles without any handshake on either side before the run is declared hung.
   localparam int unsigned STALL_LIMIT  = 3000;
   // The tail wait after the drain leaves room for the slowest item, a segment that walks past every breakpoint.
   localparam int unsigned TAIL_CYCLES  = 40;

   // The scoreboard keeps its own image of the splitter state. Every accepted item is walked
   // against that image, and each piece that the walk produces is queued until the result
   // channel hands over the matching piece.
   class piece_ledger;
      pos_type                breaks[MAX_BREAKS];
      int unsigned            loaded = 0;
      int unsigned            cursor = 0;
      logic                   parity = 1'b0;
      logic [PARENT_BITS-1:0] parent = '0;
      piece_type              expected_pieces[$];
      int unsigned            errors = 0;
      int unsigned            pieces_checked = 0;
      int unsigned            segments_split = 0;
      int unsigned            widest_split = 0;

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function string show(piece_type p);
         return $sformatf("parent=%h chrom=%0d copy=%0d start=%h end=%h last=%0d",
                          p.parent, p.chrom, p.copy, p.piece_start, p.piece_end, p.last);
      endfunction

      function void queue_piece(logic [CHROM_BITS-1:0] chrom, pos_type first, pos_type final_pos,
                                logic is_last);
         piece_type p;
         p.parent      = parent;
         p.chrom       = chrom;
         p.copy        = parity;
         p.piece_start = first;
         p.piece_end   = final_pos;
         p.last        = is_last;
         expected_pieces = {expected_pieces, p};
      endfunction

      // Works out the pieces of one accepted item and updates the state image.
      function void note_item(logic [FUNC_BITS-1:0] f, req_data_type d);
         pos_type     seg_lo, seg_hi, from, bp, prev;
         int unsigned emitted;
         emitted = 0;
         case (f)
            FUNC_START: begin
               parent = d.parent_id;
               parity = d.start_chrom;
               loaded = 0;
               cursor = 0;
            end
            FUNC_BREAK: begin
               // Breakpoints beyond the store depth are dropped.
               if (loaded < MAX_BREAKS) begin
                  breaks[loaded] = d.break_pos;
                  loaded++;
               end
            end
            FUNC_SEGMENT: begin
               seg_lo = d.seg_start;
               seg_hi = d.seg_end;
               while (1) begin
                  // A piece begins at the segment start, or at the breakpoint just passed
                  // when that one lies inside the segment.
                  from = seg_lo;
                  if (cursor > 0 && cursor <= loaded) begin
                     prev = breaks[cursor-1];
                     if (prev > seg_lo && prev <= seg_hi) from = prev;
                  end
                  if (cursor >= loaded) break;
                  bp = breaks[cursor];
                  if (bp > seg_hi && bp > seg_lo) break;
                  if (bp > seg_lo) begin
                     // Duplicate or descending breakpoints leave an empty piece, which is
                     // suppressed while the copy still flips.
                     if (from <= bp - 1) begin
                        queue_piece(d.chrom_number, from, pos_type'(bp - 1), 1'b0);
                        emitted++;
                     end
                  end
                  cursor++;
                  parity = ~parity;
               end
               if (seg_lo <= seg_hi) begin
                  queue_piece(d.chrom_number, from, seg_hi, 1'b1);
                  emitted++;
               end
               segments_split++;
               if (emitted > widest_split) widest_split = emitted;
            end
            default: ;
         endcase
      endfunction

      function void check_piece(rsp_data_type r, logic tlast);
         piece_type got, want;
         got.parent      = r.piece_parent;
         got.chrom       = r.piece_chrom_number;
         got.copy        = r.piece_copy;
         got.piece_start = r.piece_start;
         got.piece_end   = r.piece_end;
         got.last        = tlast;
         pieces_checked++;
         if (expected_pieces.size() == 0) begin
            flag({"piece with nothing expected: ", show(got)});
            return;
         end
         want = expected_pieces.pop_front();
         if (got.parent !== want.parent || got.chrom !== want.chrom || got.copy !== want.copy ||
             got.piece_start !== want.piece_start || got.piece_end !== want.piece_end ||
             got.last !== want.last)
            flag({"expected ", show(want), " got ", show(got)});
      endfunction

      function void settle_leftovers();
         if (expected_pieces.size() != 0)
            flag($sformatf("%0d expected pieces never arrived, first %s",
                           expected_pieces.size(), show(expected_pieces[0])));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // tuser: func
   logic [FUNC_BITS-1:0]     req_tuser = FUNC_START;
   // tdata from bit 0 up: parent_id, start_chrom, break_pos, seg_start, seg_end,
   // chrom_number, zero fill
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // tdata from bit 0 up: piece_parent, piece_chrom_number, piece_copy, piece_start,
   // piece_end, zero fill
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // tlast: piece_last
   logic                     rsp_tlast;

   piece_ledger ledger = new;

   int unsigned accepted_items = 0;
   int unsigned burst_left = 0;
   int unsigned groups_run = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   ancestry_segment_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver runs through phases of random length. Each phase either takes every piece,
   // takes about half, takes about one in four, or alternates in regular runs of taking and stalling.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= stall_left[2];
      endcase
   end

   // Pieces are checked at the edge where they are taken; the values read here are the ones
   // that the splitter saw at that edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_piece(rsp_data_type'(rsp_tdata), rsp_tlast);
   end

   // The watchdog ends a run in which neither side has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Every field carries random bits, so the fields that an item does not use still toggle.
   function automatic req_data_type noise_data();
      req_data_type d;
      d              = '0;
      d.parent_id    = PARENT_BITS'($urandom);
      d.start_chrom  = 1'($urandom_range(0, 1));
      d.break_pos    = pos_type'($urandom);
      d.seg_start    = pos_type'($urandom);
      d.seg_end      = pos_type'($urandom);
      d.chrom_number = CHROM_BITS'($urandom);
      return d;
   endfunction

   // The sender works in bursts. A burst ends with a random gap, and some bursts are long
   // enough to keep the input busy for a good while. In this task valid is lowered only in the
   // step that opens a gap, so it never sees two assignments in one step.
   task automatic send_item(input logic [FUNC_BITS-1:0] f, input req_data_type d);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
         gap = $urandom_range(0, 9);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      ledger.note_item(f, d);
      if (f != FUNC_UNUSED) accepted_items++;
   endtask

   task automatic send_start(input logic [PARENT_BITS-1:0] parent_id, input logic copy);
      req_data_type d;
      d             = noise_data();
      d.parent_id   = parent_id;
      d.start_chrom = copy;
      send_item(FUNC_START, d);
   endtask

   task automatic send_break(input pos_type pos);
      req_data_type d;
      d           = noise_data();
      d.break_pos = pos;
      send_item(FUNC_BREAK, d);
   endtask

   task automatic send_segment(input pos_type first, input pos_type final_pos,
                               input logic [CHROM_BITS-1:0] chrom);
      req_data_type d;
      d              = noise_data();
      d.seg_start    = first;
      d.seg_end      = final_pos;
      d.chrom_number = chrom;
      send_item(FUNC_SEGMENT, d);
   endtask

   // Holds the input back until every expected piece has been taken.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ledger.expected_pieces.size() != 0);
   endtask

   // One individual: a start item, a sorted set of breakpoints with the odd duplicate or
   // swapped pair, and a few ascending segments over the same stretch. Most stretches are
   // short so that breakpoints land inside segments; some cover the whole position range.
   task automatic run_group(input bit overflow);
      pos_type     cuts[$];
      int unsigned span, nb, nseg, extra, cur, lo, hi, k;
      pos_type     tmp;
      span = ($urandom_range(0, 7) == 0) ? POS_MAX : $urandom_range(16, 4000);
      if (overflow)
         nb = $urandom_range(MAX_BREAKS + 1, MAX_BREAKS + 4);
      else if ($urandom_range(0, 9) == 0)
         nb = $urandom_range(8, MAX_BREAKS + 4);
      else
         nb = $urandom_range(0, 6);
      for (k = 0; k < nb; k++) cuts = {cuts, pos_type'($urandom_range(0, span))};
      cuts.sort();
      if (nb > 1 && $urandom_range(0, 5) == 0) begin
         k = $urandom_range(1, nb - 1);
         cuts[k] = cuts[k-1];
      end
      if (nb > 1 && $urandom_range(0, 9) == 0) begin
         k = $urandom_range(1, nb - 1);
         tmp = cuts[k];
         cuts[k] = cuts[k-1];
         cuts[k-1] = tmp;
      end
      send_start(PARENT_BITS'($urandom), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 14) == 0) send_item(FUNC_UNUSED, noise_data());
      for (k = 0; k < nb; k++) send_break(cuts[k]);
      nseg = $urandom_range(1, 4);
      cur  = $urandom_range(0, span / 4);
      for (k = 0; k < nseg && cur <= POS_MAX; k++) begin
         lo = cur + $urandom_range(0, span / 8);
         hi = lo + $urandom_range(0, span / 2);
         if (lo > POS_MAX) lo = POS_MAX;
         if (hi > POS_MAX) hi = POS_MAX;
         // Now and then the segment comes in reversed.
         if ($urandom_range(0, 11) == 0)
            send_segment(pos_type'(hi), pos_type'(lo), CHROM_BITS'($urandom));
         else
            send_segment(pos_type'(lo), pos_type'(hi), CHROM_BITS'($urandom));
         cur = hi + 1;
      end
      // Sometimes more breakpoints follow the segments, and one more segment walks past them.
      if ($urandom_range(0, 5) == 0 && cur + 64 < POS_MAX) begin
         extra = $urandom_range(1, 3);
         for (k = 0; k < extra; k++) send_break(pos_type'(cur + 16 * k + $urandom_range(1, 15)));
         hi = cur + span;
         if (hi > POS_MAX) hi = POS_MAX;
         send_segment(pos_type'(cur), pos_type'(hi), CHROM_BITS'($urandom));
      end
      groups_run++;
   endtask

   initial begin
      int unsigned directed_items;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // An unused func code, then a segment before any start item: the held parent and copy
      // still have their reset values, and the piece spans the whole position range.
      send_item(FUNC_UNUSED, noise_data());
      send_segment(pos_type'(0), pos_type'(POS_MAX), CHROM_BITS'(63));

      // Breakpoints at zero, a duplicate pair and the top position. The first segment flips
      // on the breakpoint at its start, drops the empty piece between the duplicates and
      // stops at the top breakpoint. The next one resumes from the cursor, the reversed one
      // only consumes the top breakpoint, and the last sits on the top position itself.
      send_start(PARENT_BITS'(16'hFFFF), 1'b1);
      send_break(pos_type'(0));
      send_break(pos_type'(5));
      send_break(pos_type'(5));
      send_break(pos_type'(10));
      send_break(pos_type'(POS_MAX));
      send_segment(pos_type'(0), pos_type'(20), CHROM_BITS'(0));
      send_segment(pos_type'(30), pos_type'(40), CHROM_BITS'(21));
      send_segment(pos_type'(POS_MAX), pos_type'(3), CHROM_BITS'(42));
      send_segment(pos_type'(POS_MAX), pos_type'(POS_MAX), CHROM_BITS'(63));

      // Descending breakpoints: the second one lies behind the first and leaves no piece.
      send_start(PARENT_BITS'(0), 1'b0);
      send_break(pos_type'(100));
      send_break(pos_type'(50));
      send_segment(pos_type'(0), pos_type'(200), CHROM_BITS'(7));
      send_item(FUNC_UNUSED, req_data_type'(REQ_DATA_BITS'({REQ_RAW_BITS{1'b1}})));

      // Single-position segments on either side of one breakpoint.
      send_start(PARENT_BITS'(16'h5A5A), 1'b1);
      send_segment(pos_type'(7), pos_type'(7), CHROM_BITS'(1));
      send_break(pos_type'(1));
      send_segment(pos_type'(0), pos_type'(0), CHROM_BITS'(2));
      send_segment(pos_type'(1), pos_type'(1), CHROM_BITS'(3));
      directed_items = accepted_items;

      // The first random group overfills the breakpoint store; later ones vary freely, and
      // every sixth group the sender waits for the result channel to run dry.
      run_group(1'b1);
      while (accepted_items < directed_items + RANDOM_ITEMS) begin
         run_group(1'b0);
         if (groups_run % 6 == 0) drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      ledger.settle_leftovers();

      $display("run covered %0d items in %0d random groups and %0d segments",
               accepted_items, groups_run, ledger.segments_split);
      $display("%0d pieces checked, at most %0d from one segment, %0d failures",
               ledger.pieces_checked, ledger.widest_split, ledger.errors);
      if (ledger.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
